### hdl/qubit_gate_region_apply_defines.svh
// Assertion helpers used by the checker file.
`ifndef QUBIT_GATE_REGION_APPLY_DEFINES_SVH
`define QUBIT_GATE_REGION_APPLY_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define QGRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qgra check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define QGRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qgra check failed");

`endif

### hdl/qgra_pkg.sv
`default_nettype none
package qgra_pkg;

    localparam int QUBITS     = 10;
    localparam int AMP_WIDTH  = 16;
    localparam int FRAC       = AMP_WIDTH - 2;
    localparam int IDX_W      = QUBITS;
    localparam int DEPTH      = 1 << QUBITS;
    localparam int PACK_W     = 2 * AMP_WIDTH;
    localparam int PROD_W     = 2 * AMP_WIDTH;
    localparam int TERM_W     = PROD_W - FRAC;
    localparam int ACC_W      = TERM_W + 2;
    localparam int CNT_W      = QUBITS;

    // Port field widths
    localparam int REQ_W      = 2;
    localparam int FIELD_W    = 10;
    localparam int WORD_W     = 32;
    localparam int TBIT_W     = 4;
    localparam int KIND_W     = 2;
    localparam int PAIRS_W    = 10;
    localparam int STATUS_W   = 2;

    localparam logic signed [ACC_W-1:0] PART_MAX = ACC_W'((1 << (AMP_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] PART_MIN = -ACC_W'(1 << (AMP_WIDTH - 1));

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_GATE  = 2'd2,
        REQ_NONE  = 2'd3
    } req_kind_t;

    typedef enum logic [KIND_W-1:0] {
        GATE_DENSE = 2'd0,
        GATE_DIAG  = 2'd1,
        GATE_ANTI  = 2'd2,
        GATE_BAD   = 2'd3
    } gate_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SKIP = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_READ_CAP,
        S_RD0,
        S_RD1,
        S_CAP,
        S_MAC,
        S_WR0,
        S_WR1,
        S_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic sel;
    } mac_ctrl_t;

    function automatic logic [AMP_WIDTH-1:0] sat_part(input logic signed [ACC_W-1:0] a);
        logic [AMP_WIDTH-1:0] r;
        if (a > PART_MAX)
            r = PART_MAX[AMP_WIDTH-1:0];
        else if (a < PART_MIN)
            r = PART_MIN[AMP_WIDTH-1:0];
        else
            r = a[AMP_WIDTH-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/qgra_if.sv
`default_nettype none
interface qgra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [9:0]  index;
    logic [31:0] amp_in;
    logic [3:0]  tgt_bit;
    logic [1:0]  gate_kind;
    logic [9:0]  ctrl_mask;
    logic [9:0]  ctrl_value;
    logic [9:0]  zone_id;
    logic [31:0] coef0;
    logic [31:0] coef1;
    logic [31:0] coef2;
    logic [31:0] coef3;

    modport source (
        output valid, req_type, index, amp_in, tgt_bit, gate_kind,
               ctrl_mask, ctrl_value, zone_id, coef0, coef1, coef2, coef3,
        input  ready
    );
    modport sink (
        input  valid, req_type, index, amp_in, tgt_bit, gate_kind,
               ctrl_mask, ctrl_value, zone_id, coef0, coef1, coef2, coef3,
        output ready
    );
endinterface

interface qgra_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] amp_out;
    logic [9:0]  pairs_updated;
    logic [1:0]  status;

    modport source (output valid, amp_out, pairs_updated, status, input ready);
    modport sink   (input valid, amp_out, pairs_updated, status, output ready);
endinterface
`default_nettype wire

### hdl/qgra_ram.sv
`default_nettype none
module qgra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/qgra_mac.sv
`default_nettype none
// Complex multiply stage followed by two complex accumulators.
module qgra_mac (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire qgra_pkg::mac_ctrl_t            ctrl,
    input  wire logic [qgra_pkg::PACK_W-1:0]    coef,
    input  wire logic [qgra_pkg::PACK_W-1:0]    amp,
    output logic signed [qgra_pkg::ACC_W-1:0]   acc0_re,
    output logic signed [qgra_pkg::ACC_W-1:0]   acc0_im,
    output logic signed [qgra_pkg::ACC_W-1:0]   acc1_re,
    output logic signed [qgra_pkg::ACC_W-1:0]   acc1_im
);
    import qgra_pkg::*;

    logic signed [AMP_WIDTH-1:0] cr, ci, ar, ai;
    logic signed [PROD_W-1:0]    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic                        pvld_reg, psel_reg;
    logic signed [ACC_W-1:0]     d_re, d_im;
    logic signed [ACC_W-1:0]     acc0_re_reg, acc0_im_reg, acc1_re_reg, acc1_im_reg;

    assign cr = coef[PACK_W-1:AMP_WIDTH];
    assign ci = coef[AMP_WIDTH-1:0];
    assign ar = amp[PACK_W-1:AMP_WIDTH];
    assign ai = amp[AMP_WIDTH-1:0];

    // Floor each product by the fraction shift, then add exactly.
    always_comb
    begin
        d_re = ACC_W'(signed'(p_rr_reg[PROD_W-1:FRAC]))
             - ACC_W'(signed'(p_ii_reg[PROD_W-1:FRAC]));
        d_im = ACC_W'(signed'(p_ri_reg[PROD_W-1:FRAC]))
             + ACC_W'(signed'(p_ir_reg[PROD_W-1:FRAC]));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_rr_reg <= cr * ar;
            p_ii_reg <= ci * ai;
            p_ri_reg <= cr * ai;
            p_ir_reg <= ci * ar;
            psel_reg <= ctrl.sel;
        end
        if (ctrl.clear)
        begin
            acc0_re_reg <= '0;
            acc0_im_reg <= '0;
            acc1_re_reg <= '0;
            acc1_im_reg <= '0;
        end
        else if (pvld_reg && !psel_reg)
        begin
            acc0_re_reg <= acc0_re_reg + d_re;
            acc0_im_reg <= acc0_im_reg + d_im;
        end
        else if (pvld_reg)
        begin
            acc1_re_reg <= acc1_re_reg + d_re;
            acc1_im_reg <= acc1_im_reg + d_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= ctrl.mul_en;
        end
    end

    assign acc0_re = acc0_re_reg;
    assign acc0_im = acc0_im_reg;
    assign acc1_re = acc1_re_reg;
    assign acc1_im = acc1_im_reg;
endmodule
`default_nettype wire

### hdl/qubit_gate_region_apply.sv
// State vector of 2^QUBITS packed complex amplitudes (Q2.14 real high, imaginary
// low) held in one dual-port RAM, with single-qubit gate application over a
// region. One item is worked at a time. A gate updates pairs of amplitudes,
// where pairs is 2^(free region bits) and at most 512; a rejected or skipped
// gate updates none. Each pair costs two RAM reads, one capture step, a pass
// through the shared complex multiply and accumulate unit and two RAM writes.
// The result is held in an output register, so the next item is taken while a
// result waits for transfer. The user must write the zone mask through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// Amplitudes must be written before they are read or used by a gate.
`default_nettype none
module qubit_gate_region_apply (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [qgra_pkg::FIELD_W-1:0]   cfg_wdata,
    qgra_req_if.sink                            req,
    qgra_rsp_if.source                          rsp
);
    import qgra_pkg::*;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  zone_mask_reg;
    logic [IDX_W-1:0]  idx_reg, tmask_reg, pmask_reg, base_reg, pos_reg;
    logic [PACK_W-1:0] amp_reg, a0_reg, a1_reg, rd_amp_reg;
    logic [PACK_W-1:0] coef_reg [4];
    logic [CNT_W-1:0]  cnt_reg;
    logic [2:0]        step_reg;
    status_t           status_reg;

    logic              rsp_valid_reg;
    logic [WORD_W-1:0] rsp_amp_reg;
    logic [PAIRS_W-1:0] rsp_pairs_reg;
    status_t           rsp_status_reg;

    // Decode of the incoming gate request
    logic              accept;
    logic [IDX_W-1:0]  in_tmask, in_cmask, in_cval, in_rid, out_mask;
    logic              in_bad, in_skip;
    req_kind_t         in_req;
    gate_kind_t        in_kind;

    logic [IDX_W-1:0]  p0, p1, pos_next;
    logic              load_rsp;

    // RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [PACK_W-1:0] ram_wdata, ram_rdata;

    mac_ctrl_t         mac_ctrl;
    logic [PACK_W-1:0] mac_coef, mac_amp;
    logic signed [ACC_W-1:0] acc0_re, acc0_im, acc1_re, acc1_im;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign in_req   = req_kind_t'(req.req_type);
    assign in_kind  = gate_kind_t'(req.gate_kind);
    assign in_cmask = IDX_W'(req.ctrl_mask);
    assign in_cval  = IDX_W'(req.ctrl_value);
    assign in_rid   = IDX_W'(req.zone_id);
    assign out_mask = ~zone_mask_reg;
    assign in_tmask = IDX_W'(1) << req.tgt_bit;
    assign in_bad   = (in_kind == GATE_BAD) || (32'(req.tgt_bit) >= QUBITS);
    assign in_skip  = (in_cmask != '0)
                   && ((in_cmask & in_rid & out_mask) != (in_cval & out_mask));

    // Pair addresses and the masked increment over the free region bits
    assign p0       = (pos_reg | base_reg) & ~tmask_reg;
    assign p1       = p0 | tmask_reg;
    assign pos_next = (pos_reg + (~pmask_reg + IDX_W'(1))) & pmask_reg;
    assign load_rsp = (state_reg == S_FIN) && (!rsp_valid_reg || rsp.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_req)
                        REQ_WRITE: state_next = S_WRITE;
                        REQ_READ:  state_next = S_READ;
                        REQ_GATE:  state_next = (in_bad || in_skip) ? S_FIN : S_RD0;
                        REQ_NONE:  state_next = S_FIN;
                    endcase
                end
            end
            S_WRITE:    state_next = S_FIN;
            S_READ:     state_next = S_READ_CAP;
            S_READ_CAP: state_next = S_FIN;
            S_RD0:      state_next = S_RD1;
            S_RD1:      state_next = S_CAP;
            S_CAP:      state_next = S_MAC;
            S_MAC:      state_next = (step_reg == 3'd4) ? S_WR0 : S_MAC;
            S_WR0:      state_next = S_WR1;
            S_WR1:      state_next = (pos_next == '0) ? S_FIN : S_RD0;
            S_FIN:      state_next = load_rsp ? S_IDLE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory and multiply unit controls
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = amp_reg;
        ram_raddr = idx_reg;
        mac_ctrl  = '0;
        unique case (state_reg)
            S_WRITE: ram_we = 1'b1;
            S_RD0:
            begin
                ram_raddr      = p0;
                mac_ctrl.clear = 1'b1;
            end
            S_RD1:   ram_raddr = p1;
            S_MAC:
            begin
                mac_ctrl.mul_en = (step_reg != 3'd4);
                mac_ctrl.sel    = step_reg[1];
            end
            S_WR0:
            begin
                ram_we    = 1'b1;
                ram_waddr = p0;
                ram_wdata = {sat_part(acc0_re), sat_part(acc0_im)};
            end
            S_WR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = p1;
                ram_wdata = {sat_part(acc1_re), sat_part(acc1_im)};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Step 0: c00*a0, 1: c01*a1 into the first sum; 2: c10*a0, 3: c11*a1
    assign mac_coef = coef_reg[step_reg[1:0]];
    assign mac_amp  = step_reg[0] ? a1_reg : a0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            zone_mask_reg <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                zone_mask_reg <= IDX_W'(cfg_wdata);
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg    <= IDX_W'(req.index);
            amp_reg    <= PACK_W'(req.amp_in);
            tmask_reg  <= in_tmask;
            base_reg   <= (in_rid & out_mask)
                        | ((in_cmask != '0) ? (in_cval & in_cmask & zone_mask_reg) : '0);
            pmask_reg  <= zone_mask_reg & ~in_tmask & ~in_cmask;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            rd_amp_reg <= '0;
            // Zero the entries a sparse gate does not use
            coef_reg[0] <= (in_kind == GATE_ANTI) ? '0 : PACK_W'(req.coef0);
            coef_reg[1] <= (in_kind == GATE_DIAG) ? '0 : PACK_W'(req.coef1);
            coef_reg[2] <= (in_kind == GATE_DIAG) ? '0 : PACK_W'(req.coef2);
            coef_reg[3] <= (in_kind == GATE_ANTI) ? '0 : PACK_W'(req.coef3);
            if (in_req == REQ_GATE && in_bad)
                status_reg <= ST_BAD;
            else if (in_req == REQ_GATE && in_skip)
                status_reg <= ST_SKIP;
            else
                status_reg <= ST_OK;
        end
        if (state_reg == S_READ_CAP)
        begin
            rd_amp_reg <= ram_rdata;
        end
        if (state_reg == S_RD1)
        begin
            a0_reg <= ram_rdata;
        end
        if (state_reg == S_CAP)
        begin
            a1_reg   <= ram_rdata;
            step_reg <= '0;
        end
        if (state_reg == S_MAC)
        begin
            step_reg <= step_reg + 3'd1;
        end
        if (state_reg == S_WR1)
        begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (load_rsp)
        begin
            rsp_amp_reg    <= WORD_W'(rd_amp_reg);
            rsp_pairs_reg  <= PAIRS_W'(cnt_reg);
            rsp_status_reg <= status_reg;
        end
    end

    qgra_ram #(
        .WIDTH (PACK_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qgra_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .amp     (mac_amp),
        .acc0_re (acc0_re),
        .acc0_im (acc0_im),
        .acc1_re (acc1_re),
        .acc1_im (acc1_im)
    );

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.amp_out       = rsp_amp_reg;
    assign rsp.pairs_updated = rsp_pairs_reg;
    assign rsp.status        = rsp_status_reg;
endmodule
`default_nettype wire

### hdl/qgra_chk.sv
`default_nettype none
`include "qubit_gate_region_apply_defines.svh"
module qgra_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] amp_out,
    input wire logic [9:0]  pairs_updated,
    input wire logic [1:0]  status
);
    import qgra_pkg::*;

    `QGRA_ASSERT_NOW(a_bad_no_pairs, clk, rst_n, rsp_valid && status == ST_BAD, pairs_updated == '0)
    `QGRA_ASSERT_NOW(a_pairs_ok, clk, rst_n, rsp_valid && pairs_updated != '0, status == ST_OK)
    `QGRA_ASSERT_NOW(a_fail_no_amp, clk, rst_n, rsp_valid && status != ST_OK, amp_out == '0)
    `QGRA_ASSERT_NEXT(a_one_item, clk, rst_n, req_valid && req_ready, !req_ready)
    `QGRA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind qubit_gate_region_apply qgra_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .amp_out       (rsp.amp_out),
    .pairs_updated (rsp.pairs_updated),
    .status        (rsp.status)
);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import qgra_pkg::*;

    // Entries written first; every later access stays inside them but at entry 3FF.
    localparam int FILL_N = 256;

    // One request as the driver sees it, and one result as the checker sees it.
    typedef struct {
        req_kind_t   rq;
        logic [9:0]  idx;
        logic [31:0] amp;
        logic [3:0]  tgt;
        gate_kind_t  gk;
        logic [9:0]  cm;
        logic [9:0]  cv;
        logic [9:0]  rid;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
    } req_item_t;

    typedef struct {
        logic [31:0] amp;
        logic [9:0]  pairs;
        status_t     st;
    } rsp_item_t;

    // Directed stimulus row: either a zone mask change or a request,
    // optionally with a hand-typed result.
    typedef struct {
        bit         is_cfg;
        logic [9:0] cfg;
        req_item_t  it;
        bit         typed;
        rsp_item_t  exp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [FIELD_W-1:0] cfg_wdata;

    qgra_req_if req ();
    qgra_rsp_if rsp ();

    qubit_gate_region_apply uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // Shadow copy of the amplitude store and the zone register.
    logic [31:0] amp_shadow [DEPTH];
    logic [9:0]  mask_shadow;

    rsp_item_t   pending_rsp [$];
    dir_row_t    dir_rows [$];
    int          fails;
    int          snd_idle;
    int          rcv_idle;
    int          n_sent;

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // ------------------------------------------------------------------
    // Gate arithmetic: Q2.14 parts, floored products, saturated sums.
    // ------------------------------------------------------------------
    function automatic longint part(input logic [31:0] w, input bit hi);
        logic signed [15:0] p;
        p = hi ? w[31:16] : w[15:0];
        return longint'(p);
    endfunction

    // Arithmetic shift on a signed value floors toward minus infinity.
    function automatic longint fl_prod(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic void cmul_acc(inout longint re, inout longint im,
                                     input logic [31:0] c, input logic [31:0] a);
        longint cr, ci, ar, ai;
        cr = part(c, 1'b1);
        ci = part(c, 1'b0);
        ar = part(a, 1'b1);
        ai = part(a, 1'b0);
        re += fl_prod(cr, ar) - fl_prod(ci, ai);
        im += fl_prod(cr, ai) + fl_prod(ci, ar);
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // Advance the shadow store by one request and return its result.
    function automatic rsp_item_t apply_request(input req_item_t it);
        rsp_item_t   r;
        logic [9:0]  tmask, base, pmask, pos, p0, p1;
        logic [31:0] a0, a1;
        longint      r0, i0, r1, i1;
        int          npairs;
        r.amp   = '0;
        r.pairs = '0;
        r.st    = ST_OK;
        case (it.rq)
            REQ_WRITE: amp_shadow[it.idx] = it.amp;
            REQ_READ:  r.amp = amp_shadow[it.idx];
            REQ_GATE:
            begin
                if (it.gk == GATE_BAD || it.tgt >= QUBITS)
                    r.st = ST_BAD;
                else if (it.cm != 0 && (it.cm & it.rid & ~mask_shadow) != (it.cv & ~mask_shadow))
                    r.st = ST_SKIP;
                else
                begin
                    tmask = 10'd1 << it.tgt;
                    base  = it.rid & ~mask_shadow;
                    pmask = mask_shadow & ~tmask;
                    if (it.cm != 0)
                    begin
                        base  |= it.cv & it.cm & mask_shadow;
                        pmask &= ~it.cm;
                    end
                    npairs  = 1 << $countones(pmask);
                    r.pairs = 10'(npairs);
                    pos     = '0;
                    for (int k = 0; k < npairs; k++)
                    begin
                        p0 = (pos | base) & ~tmask;
                        p1 = p0 | tmask;
                        a0 = amp_shadow[p0];
                        a1 = amp_shadow[p1];
                        r0 = 0; i0 = 0; r1 = 0; i1 = 0;
                        // Masked increment: carry ripples only through walk bits.
                        pos = (pos + (~pmask + 10'd1)) & pmask;
                        if (it.gk == GATE_DENSE)
                        begin
                            cmul_acc(r0, i0, it.c0, a0);
                            cmul_acc(r0, i0, it.c1, a1);
                            cmul_acc(r1, i1, it.c2, a0);
                            cmul_acc(r1, i1, it.c3, a1);
                        end
                        else if (it.gk == GATE_DIAG)
                        begin
                            cmul_acc(r0, i0, it.c0, a0);
                            cmul_acc(r1, i1, it.c3, a1);
                        end
                        else
                        begin
                            cmul_acc(r0, i0, it.c1, a1);
                            cmul_acc(r1, i1, it.c2, a0);
                        end
                        amp_shadow[p0] = {clamp16(r0), clamp16(i0)};
                        amp_shadow[p1] = {clamp16(r1), clamp16(i1)};
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    // Indices, zone ids and targets stay inside the filled lower quarter.
    function automatic req_item_t blank_req(input req_kind_t rq);
        req_item_t it;
        it.rq  = rq;
        it.idx = 10'($urandom_range(FILL_N - 1));
        it.amp = $urandom;
        it.tgt = 4'($urandom_range(7));
        it.gk  = GATE_DENSE;
        it.cm  = '0;
        it.cv  = 10'($urandom);
        it.rid = 10'($urandom_range(FILL_N - 1));
        it.c0  = $urandom;
        it.c1  = $urandom;
        it.c2  = $urandom;
        it.c3  = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(5))
            0: return 32'h4000_0000;   // 1.0
            1: return 32'h0000_0000;
            2: return 32'hC000_0000;   // -1.0
            3: return 32'h2D41_2D41;   // (1+i)/sqrt(2)
            default: return $urandom;
        endcase
    endfunction

    // Build one random request for the current region. Mostly well-formed
    // gates with few free walk bits; some reads, writes and malformed items.
    function automatic req_item_t random_req(input logic [9:0] rmask);
        req_item_t  it;
        logic [9:0] free_bits;
        int         sel, b;
        sel = $urandom_range(99);
        if (sel < 10)
            it = blank_req(REQ_WRITE);
        else if (sel < 20)
            it = blank_req(REQ_READ);
        else if (sel < 24)
            it = blank_req(REQ_NONE);
        else
        begin
            it    = blank_req(REQ_GATE);
            it.gk = gate_kind_t'($urandom_range(2));
            it.c0 = pick_coef();
            it.c1 = pick_coef();
            it.c2 = pick_coef();
            it.c3 = pick_coef();
            if (sel < 28)
                it.gk = GATE_BAD;
            else if (sel < 31)
                it.tgt = 4'($urandom_range(10, 15));
            // Rarely let an uncontrolled gate walk the whole region.
            if ($urandom_range(99) < 2 || $countones(rmask) <= 5)
                it.cm = ($urandom_range(1)) ? 10'($urandom) : '0;
            else
            begin
                it.cm = 10'($urandom);
                free_bits = rmask & ~it.cm;
                while ($countones(free_bits) > 5)
                begin
                    b = $urandom_range(9);
                    it.cm[b] = 1'b1;
                    free_bits[b] = 1'b0;
                end
            end
            // Hold the control bits outside the region at a matching value most times.
            if ($urandom_range(99) < 75)
                it.cv = (it.rid & it.cm & ~rmask) | (10'($urandom) & rmask);
        end
        return it;
    endfunction

    function automatic dir_row_t req_row(input req_item_t it);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.cfg    = '0;
        r.it     = it;
        r.typed  = 1'b0;
        r.exp    = '{amp: '0, pairs: '0, st: ST_OK};
        return r;
    endfunction

    function automatic dir_row_t typed_row(input req_item_t it, input logic [31:0] amp,
                                           input logic [9:0] pairs, input status_t st);
        dir_row_t r;
        r       = req_row(it);
        r.typed = 1'b1;
        r.exp   = '{amp: amp, pairs: pairs, st: st};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [9:0] m);
        dir_row_t r;
        r        = req_row(blank_req(REQ_NONE));
        r.is_cfg = 1'b1;
        r.cfg    = m;
        return r;
    endfunction

    function automatic req_item_t gate_req(input logic [3:0] tgt, input gate_kind_t gk,
                                           input logic [9:0] cm, input logic [9:0] cv,
                                           input logic [9:0] rid);
        req_item_t it;
        it     = blank_req(REQ_GATE);
        it.tgt = tgt;
        it.gk  = gk;
        it.cm  = cm;
        it.cv  = cv;
        it.rid = rid;
        return it;
    endfunction

    task automatic add_row(input dir_row_t r);
        dir_rows = {dir_rows, r};
    endtask

    task automatic build_directed();
        req_item_t it;
        it = blank_req(REQ_WRITE); it.idx = 10'd0; it.amp = 32'h7FFF_8000;
        add_row(typed_row(it, '0, '0, ST_OK));
        it = blank_req(REQ_READ); it.idx = 10'd0;
        add_row(typed_row(it, 32'h7FFF_8000, '0, ST_OK));
        it = blank_req(REQ_WRITE); it.idx = 10'h3FF; it.amp = 32'hFFFF_FFFF;
        add_row(typed_row(it, '0, '0, ST_OK));
        it = blank_req(REQ_READ); it.idx = 10'h3FF;
        add_row(typed_row(it, 32'hFFFF_FFFF, '0, ST_OK));
        // Unknown request: no effect, all-zero result.
        add_row(typed_row(blank_req(REQ_NONE), '0, '0, ST_OK));
        // Invalid gate kind, and targets at or above the qubit count.
        add_row(typed_row(gate_req(4'd0, GATE_BAD, '0, '0, '0), '0, '0, ST_BAD));
        add_row(typed_row(gate_req(4'd10, GATE_DENSE, '0, '0, '0), '0, '0, ST_BAD));
        add_row(typed_row(gate_req(4'd15, GATE_DIAG, 10'h3FF, '0, '0), '0, '0, ST_BAD));
        // Near-identity dense gate, top bits held low by controls: 128 pairs.
        it = gate_req(4'd0, GATE_DENSE, 10'h300, 10'h055, 10'h2AA);
        it.c0 = 32'h4000_0000; it.c1 = '0; it.c2 = '0; it.c3 = 32'h3FFF_0001;
        add_row(typed_row(it, '0, 10'd128, ST_OK));
        it = blank_req(REQ_READ); it.idx = 10'd0;
        add_row(req_row(it));
        // Diagonal with extreme coefficients, eight control bits.
        it = gate_req(4'd7, GATE_DIAG, 10'h33F, 10'h0AA, 10'h000);
        it.c0 = 32'h7FFF_7FFF; it.c3 = 32'h8000_8000;
        add_row(req_row(it));
        // Anti-diagonal with a control on the target bit itself.
        add_row(req_row(gate_req(4'd3, GATE_ANTI, 10'h3F8, 10'h0FF, 10'h000)));
        it = blank_req(REQ_READ); it.idx = 10'd1;
        add_row(req_row(it));
        add_row(cfg_row(10'h00F));
        // Target outside the region; uncontrolled gate ignores ctrl_value.
        add_row(req_row(gate_req(4'd7, GATE_DENSE, '0, 10'h3C5, 10'h0FF)));
        // Control mismatch outside the region.
        add_row(typed_row(gate_req(4'd0, GATE_DIAG, 10'h030, 10'h020, 10'h010),
                          '0, '0, ST_SKIP));
        // Matching control with a stray ctrl_value bit inside the region.
        add_row(req_row(gate_req(4'd1, GATE_ANTI, 10'h035, 10'h018, 10'h0D0)));
        add_row(cfg_row(10'h000));
        // Empty region: exactly one pair, saturating coefficients.
        it = gate_req(4'd4, GATE_DENSE, '0, '0, 10'h0A5);
        it.c0 = 32'h8000_8000; it.c1 = 32'h8000_8000; it.c2 = 32'h7FFF_7FFF; it.c3 = 32'h8000_8000;
        add_row(typed_row(it, '0, 10'd1, ST_OK));
        it = blank_req(REQ_READ); it.idx = 10'h0A5;
        add_row(req_row(it));
        it = blank_req(REQ_READ); it.idx = 10'h0B5;
        add_row(req_row(it));
    endtask

    // ------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------

    // Offer one request, hold it until the transfer, then record its result.
    task automatic send_req(input req_item_t it, input bit typed, input rsp_item_t exp);
        rsp_item_t want;
        int        gap;
        // Swap idling roles after a third of the items, then stop idling.
        if (n_sent == 193)
        begin
            snd_idle = 83;
            rcv_idle = 13;
        end
        else if (n_sent == 386)
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        n_sent++;
        if ($urandom_range(99) < snd_idle)
        begin
            req.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        req.req_type   <= it.rq;
        req.index      <= it.idx;
        req.amp_in     <= it.amp;
        req.tgt_bit    <= it.tgt;
        req.gate_kind  <= it.gk;
        req.ctrl_mask  <= it.cm;
        req.ctrl_value <= it.cv;
        req.zone_id    <= it.rid;
        req.coef0      <= it.c0;
        req.coef1      <= it.c1;
        req.coef2      <= it.c2;
        req.coef3      <= it.c3;
        req.valid      <= 1'b1;
        do @(posedge clk); while (!req.ready);
        // Advance the shadow state even when the result was typed by hand.
        want = apply_request(it);
        pending_rsp = {pending_rsp, (typed ? exp : want)};
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Change the zone mask only while the block is idle.
    task automatic set_region(input logic [9:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mask_shadow = m;
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and in-order compare.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_item_t want;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (pending_rsp.size() == 0)
                    report("unexpected transfer", rsp.amp_out, '0);
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.amp_out !== want.amp)
                        report("amp_out", rsp.amp_out, want.amp);
                    if (rsp.pairs_updated !== want.pairs)
                        report("pairs_updated", 32'(rsp.pairs_updated), 32'(want.pairs));
                    if (rsp.status !== want.st)
                        report("status", 32'(rsp.status), 32'(want.st));
                end
            end
            rsp.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_item_t   none;
        logic [9:0]  phase_mask [4];
        req_item_t   it;
        fails    = 0;
        n_sent   = 0;
        snd_idle = 13;
        rcv_idle = 83;
        none     = '{amp: '0, pairs: '0, st: ST_OK};
        mask_shadow = 10'h3FF;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.req_type   = REQ_NONE;
        req.index      = '0;
        req.amp_in     = '0;
        req.tgt_bit    = '0;
        req.gate_kind  = GATE_DENSE;
        req.ctrl_mask  = '0;
        req.ctrl_value = '0;
        req.zone_id    = '0;
        req.coef0 = '0;
        req.coef1 = '0;
        req.coef2 = '0;
        req.coef3 = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the lower quarter of the store; no gate leaves it, one read goes to 3FF.
        for (int i = 0; i < FILL_N; i++)
        begin
            it = blank_req(REQ_WRITE);
            it.idx = 10'(i);
            send_req(it, 1'b0, none);
        end

        build_directed();
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                set_region(dir_rows[i].cfg);
            else
                send_req(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].exp);
        end

        // Random part: four zone settings within the filled quarter.
        phase_mask[0] = 10'h000;
        phase_mask[1] = 10'($urandom) & 10'($urandom) & 10'h0FF;
        phase_mask[2] = 10'h0FF;
        phase_mask[3] = 10'($urandom) & 10'h0FF;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_region(phase_mask[ph]);
            for (int k = 0; k < 76; k++)
            begin
                // Once mid-phase, hold off until the block has emptied.
                if (ph == 1 && k == 38)
                    drain();
                send_req(random_req(mask_shadow), 1'b0, none);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
